@@ design/atl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atl_pkg - shared constants and tables for the accelerometer tilt-angle core
// Widths, pipeline depths, the arctangent table and the output limits.
// ----------------------------------------------------------------------------
package atl_pkg;

   localparam int ATL_ANGLE_FRAC_BITS = 13;   // 8..13
   localparam int ATL_IN_FRAC         = 20;
   localparam int ATL_ANG_Q           = 30;
   localparam int ATL_SQRT_STEPS      = 28;
   localparam int ATL_CORDIC_STEPS    = 28;
   localparam int ATL_OUT_SHIFT       = ATL_ANG_Q - ATL_ANGLE_FRAC_BITS;
   localparam int ATL_LATENCY         = ATL_SQRT_STEPS + ATL_CORDIC_STEPS + 2;

   localparam longint ATL_HALF_PI_Q30 = 64'd1686629713;
   localparam longint ATL_PI_Q30      = 64'd3373259426;

   localparam logic signed [33:0] ATL_HALF_PI = 34'(ATL_HALF_PI_Q30);
   localparam logic signed [33:0] ATL_HALF_OUT =
      34'((ATL_HALF_PI_Q30 + (64'd1 << (ATL_OUT_SHIFT - 1))) >> ATL_OUT_SHIFT);
   localparam logic signed [33:0] ATL_FULL_OUT =
      34'((ATL_PI_Q30 + (64'd1 << (ATL_OUT_SHIFT - 1))) >> ATL_OUT_SHIFT);
   localparam logic signed [33:0] ATL_ROUND_HALF = 34'(64'd1 << (ATL_OUT_SHIFT - 1));

   typedef logic signed [8:0]  num_type;    // numerator reading, -z fits
   typedef logic [15:0]        sum_type;    // sum of two squares
   typedef logic [27:0]        root_type;   // Q20 root
   typedef logic signed [31:0] vec_type;    // CORDIC vector and angle

   // atan(2^-i) in Q30, truncated except for i = 27, which is rounded up
   function automatic vec_type atl_atan(input int i);
      vec_type t;
      case (i)
         0:  t = 32'sh3243F6A8;
         1:  t = 32'sh1DAC6705;
         2:  t = 32'sh0FADBAFC;
         3:  t = 32'sh07F56EA6;
         4:  t = 32'sh03FEAB76;
         5:  t = 32'sh01FFD55B;
         6:  t = 32'sh00FFFAAA;
         7:  t = 32'sh007FFF55;
         8:  t = 32'sh003FFFEA;
         9:  t = 32'sh001FFFFD;
         10: t = 32'sh000FFFFF;
         11: t = 32'sh0007FFFF;
         12: t = 32'sh0003FFFF;
         13: t = 32'sh0001FFFF;
         14: t = 32'sh0000FFFF;
         15: t = 32'sh00007FFF;
         16: t = 32'sh00003FFF;
         17: t = 32'sh00001FFF;
         18: t = 32'sh00000FFF;
         19: t = 32'sh000007FF;
         20: t = 32'sh000003FF;
         21: t = 32'sh000001FF;
         22: t = 32'sh000000FF;
         23: t = 32'sh0000007F;
         24: t = 32'sh0000003F;
         25: t = 32'sh0000001F;
         26: t = 32'sh0000000F;
         27: t = 32'sh00000008;
         default: t = 32'sh00000000;
      endcase
      return t;
   endfunction

endpackage

@@ design/atl_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atl_sqrt - pipelined integer square root, one root bit per stage
// Returns floor(sqrt(sum * 2^40)); carries the numerator and a tag alongside.
// ----------------------------------------------------------------------------
module atl_sqrt (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  atl_pkg::sum_type    in_sum,
   input  atl_pkg::num_type    in_num,
   input  logic                in_tag,
   output logic                out_valid,
   output atl_pkg::root_type   out_root,
   output atl_pkg::num_type    out_num,
   output logic                out_tag
);

   localparam int N = atl_pkg::ATL_SQRT_STEPS;

   logic               v_ff   [1:N];
   logic [31:0]        r_ff   [1:N];
   atl_pkg::root_type  q_ff   [1:N];
   atl_pkg::sum_type   s_ff   [1:N];
   atl_pkg::num_type   num_ff [1:N];
   logic               tag_ff [1:N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      localparam int P = N - 1 - k;   // radicand bit pair taken here
      logic              v_src;
      logic [31:0]       r_src;
      atl_pkg::root_type q_src;
      atl_pkg::sum_type  s_src;
      atl_pkg::num_type  num_src;
      logic              tag_src;
      logic [1:0]        pair;
      logic [31:0]       r_sh;
      logic [31:0]       trial;
      logic [31:0]       r_in;
      atl_pkg::root_type q_in;

      if (k == 0) begin : g_first
         assign v_src   = in_valid;
         assign r_src   = '0;
         assign q_src   = '0;
         assign s_src   = in_sum;
         assign num_src = in_num;
         assign tag_src = in_tag;
      end else begin : g_next
         assign v_src   = v_ff[k];
         assign r_src   = r_ff[k];
         assign q_src   = q_ff[k];
         assign s_src   = s_ff[k];
         assign num_src = num_ff[k];
         assign tag_src = tag_ff[k];
      end

      // the low 40 radicand bits are zero
      if (P >= 20) begin : g_pair
         assign pair = s_src[2*(P-20)+1 -: 2];
      end else begin : g_zero
         assign pair = 2'b00;
      end

      assign r_sh  = {r_src[29:0], pair};
      assign trial = {2'b00, q_src, 2'b01};

      always_comb begin
         if (r_sh >= trial) begin
            r_in = r_sh - trial;
            q_in = {q_src[26:0], 1'b1};
         end else begin
            r_in = r_sh;
            q_in = {q_src[26:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else begin
            v_ff[k+1] <= v_src;
         end
         r_ff[k+1]   <= r_in;
         q_ff[k+1]   <= q_in;
         s_ff[k+1]   <= s_src;
         num_ff[k+1] <= num_src;
         tag_ff[k+1] <= tag_src;
      end
   end

   assign out_valid = v_ff[N];
   assign out_root  = q_ff[N];
   assign out_num   = num_ff[N];
   assign out_tag   = tag_ff[N];

endmodule

@@ design/atl_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atl_cordic - pipelined CORDIC vectoring, one rotation per stage
// atan2(num, den) in Q30 for den >= 0.
// ----------------------------------------------------------------------------
module atl_cordic (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  atl_pkg::root_type   in_den,
   input  atl_pkg::num_type    in_num,
   input  logic                in_tag,
   output logic                out_valid,
   output atl_pkg::vec_type    out_angle,
   output logic                out_tag
);

   localparam int N = atl_pkg::ATL_CORDIC_STEPS;

   logic              v_ff   [1:N];
   atl_pkg::vec_type  x_ff   [1:N];
   atl_pkg::vec_type  y_ff   [1:N];
   atl_pkg::vec_type  a_ff   [1:N];
   logic              tag_ff [1:N];

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic             v_src;
      atl_pkg::vec_type x_src;
      atl_pkg::vec_type y_src;
      atl_pkg::vec_type a_src;
      logic             tag_src;
      atl_pkg::vec_type xs;
      atl_pkg::vec_type ys;
      atl_pkg::vec_type x_in;
      atl_pkg::vec_type y_in;
      atl_pkg::vec_type a_in;

      if (i == 0) begin : g_first
         assign v_src   = in_valid;
         assign x_src   = atl_pkg::vec_type'({4'b0000, in_den});
         assign y_src   = atl_pkg::vec_type'({{3{in_num[8]}}, in_num, 20'd0});
         assign a_src   = '0;
         assign tag_src = in_tag;
      end else begin : g_next
         assign v_src   = v_ff[i];
         assign x_src   = x_ff[i];
         assign y_src   = y_ff[i];
         assign a_src   = a_ff[i];
         assign tag_src = tag_ff[i];
      end

      assign xs = x_src >>> i;
      assign ys = y_src >>> i;

      always_comb begin
         if (y_src > 0) begin
            x_in = x_src + ys;
            y_in = y_src - xs;
            a_in = a_src + atl_pkg::atl_atan(i);
         end else begin
            x_in = x_src - ys;
            y_in = y_src + xs;
            a_in = a_src - atl_pkg::atl_atan(i);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else begin
            v_ff[i+1] <= v_src;
         end
         x_ff[i+1]   <= x_in;
         y_ff[i+1]   <= y_in;
         a_ff[i+1]   <= a_in;
         tag_ff[i+1] <= tag_src;
      end
   end

   assign out_valid = v_ff[N];
   assign out_angle = a_ff[N];
   assign out_tag   = tag_ff[N];

endmodule

@@ design/accel_tilt_angles_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_tilt_angles_core - roll, pitch and yaw from one accelerometer sample
// Three lanes, each a square-root pipeline feeding a CORDIC pipeline.
// ----------------------------------------------------------------------------
//
//  channel   ports                                   handshake
//  -------   -------------------------------------   -------------------------
//  request   req_x_sample, req_y_sample,            taken when start && !busy
//            req_z_sample
//  response  rsp_roll_angle, rsp_pitch_angle,        one-cycle rsp_valid strobe
//            rsp_yaw_angle
//
//  A new word can be taken every cycle; busy is always low.
//  The pipe holds one squaring stage, 28 root stages (one root bit
//  each), 28 CORDIC stages (one rotation each) and one round/clamp stage.
//  Synchronous reset clears the valid bits; data registers are not reset.
//  Nothing can stall the pipe, so no word is ever held back or dropped.
//
//  roll  = atan2(x, sqrt(y^2+z^2))
//  pitch = atan2(y, sqrt(x^2+z^2))
//  yaw   = pi/2 + atan2(-z, sqrt(x^2+y^2))
//  All three are forced to zero for an all-zero sample.
// ----------------------------------------------------------------------------
module accel_tilt_angles_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [7:0]  req_x_sample,
   input  logic signed [7:0]  req_y_sample,
   input  logic signed [7:0]  req_z_sample,
   output logic               rsp_valid,
   output logic signed [14:0] rsp_roll_angle,
   output logic signed [14:0] rsp_pitch_angle,
   output logic [14:0]        rsp_yaw_angle
);

   // ---- stage 0: squares and sums -----------------------------------------
   logic              v0_ff;
   atl_pkg::sum_type  syz_ff, sxz_ff, sxy_ff;
   atl_pkg::num_type  nx_ff, ny_ff, nz_ff;
   logic              zero_ff;

   // readings widened first so the squares keep all 16 bits
   logic signed [15:0] wx, wy, wz;
   assign wx = 16'(req_x_sample);
   assign wy = 16'(req_y_sample);
   assign wz = 16'(req_z_sample);

   logic [15:0] xx, yy, zz;
   assign xx = 16'(wx * wx);
   assign yy = 16'(wy * wy);
   assign zz = 16'(wz * wz);

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start && !busy;
      end
      syz_ff  <= yy + zz;
      sxz_ff  <= xx + zz;
      sxy_ff  <= xx + yy;
      nx_ff   <= atl_pkg::num_type'(req_x_sample);
      ny_ff   <= atl_pkg::num_type'(req_y_sample);
      nz_ff   <= -atl_pkg::num_type'(req_z_sample);   // yaw lane works on -z
      zero_ff <= (req_x_sample == 8'sd0) && (req_y_sample == 8'sd0) &&
                 (req_z_sample == 8'sd0);
   end

   // ---- root pipelines -----------------------------------------------------
   logic              sq_v_r, sq_v_p, sq_v_y;
   atl_pkg::root_type rt_r, rt_p, rt_y;
   atl_pkg::num_type  nm_r, nm_p, nm_y;
   logic              tg_r, tg_p, tg_y;

   atl_sqrt u_sqrt_roll (
      .clock, .reset,
      .in_valid (v0_ff), .in_sum (syz_ff), .in_num (nx_ff), .in_tag (zero_ff),
      .out_valid (sq_v_r), .out_root (rt_r), .out_num (nm_r), .out_tag (tg_r)
   );

   atl_sqrt u_sqrt_pitch (
      .clock, .reset,
      .in_valid (v0_ff), .in_sum (sxz_ff), .in_num (ny_ff), .in_tag (zero_ff),
      .out_valid (sq_v_p), .out_root (rt_p), .out_num (nm_p), .out_tag (tg_p)
   );

   atl_sqrt u_sqrt_yaw (
      .clock, .reset,
      .in_valid (v0_ff), .in_sum (sxy_ff), .in_num (nz_ff), .in_tag (zero_ff),
      .out_valid (sq_v_y), .out_root (rt_y), .out_num (nm_y), .out_tag (tg_y)
   );

   // ---- CORDIC pipelines ---------------------------------------------------
   logic             cd_v_r, cd_v_p, cd_v_y;
   atl_pkg::vec_type ang_r, ang_p, ang_y;
   logic             zt_r, zt_p, zt_y;

   atl_cordic u_cordic_roll (
      .clock, .reset,
      .in_valid (sq_v_r), .in_den (rt_r), .in_num (nm_r), .in_tag (tg_r),
      .out_valid (cd_v_r), .out_angle (ang_r), .out_tag (zt_r)
   );

   atl_cordic u_cordic_pitch (
      .clock, .reset,
      .in_valid (sq_v_p), .in_den (rt_p), .in_num (nm_p), .in_tag (tg_p),
      .out_valid (cd_v_p), .out_angle (ang_p), .out_tag (zt_p)
   );

   atl_cordic u_cordic_yaw (
      .clock, .reset,
      .in_valid (sq_v_y), .in_den (rt_y), .in_num (nm_y), .in_tag (tg_y),
      .out_valid (cd_v_y), .out_angle (ang_y), .out_tag (zt_y)
   );

   // ---- round, clamp, register --------------------------------------------
   // All lanes run in lockstep; their valid bits and zero tags are ANDed.
   logic signed [33:0] q_r, q_p, q_y;
   logic signed [33:0] o_r, o_p, o_y;
   logic signed [33:0] c_r, c_p, c_y;
   logic               all_zero;

   assign all_zero = zt_r && zt_p && zt_y;

   assign q_r = 34'(ang_r);
   assign q_p = 34'(ang_p);
   assign q_y = 34'(ang_y) + atl_pkg::ATL_HALF_PI;

   assign o_r = (q_r + atl_pkg::ATL_ROUND_HALF) >>> atl_pkg::ATL_OUT_SHIFT;
   assign o_p = (q_p + atl_pkg::ATL_ROUND_HALF) >>> atl_pkg::ATL_OUT_SHIFT;
   assign o_y = (q_y + atl_pkg::ATL_ROUND_HALF) >>> atl_pkg::ATL_OUT_SHIFT;

   always_comb begin
      if (all_zero) begin
         c_r = '0;
      end else if (o_r > atl_pkg::ATL_HALF_OUT) begin
         c_r = atl_pkg::ATL_HALF_OUT;
      end else if (o_r < -atl_pkg::ATL_HALF_OUT) begin
         c_r = -atl_pkg::ATL_HALF_OUT;
      end else begin
         c_r = o_r;
      end

      if (all_zero) begin
         c_p = '0;
      end else if (o_p > atl_pkg::ATL_HALF_OUT) begin
         c_p = atl_pkg::ATL_HALF_OUT;
      end else if (o_p < -atl_pkg::ATL_HALF_OUT) begin
         c_p = -atl_pkg::ATL_HALF_OUT;
      end else begin
         c_p = o_p;
      end

      if (all_zero) begin
         c_y = '0;
      end else if (o_y > atl_pkg::ATL_FULL_OUT) begin
         c_y = atl_pkg::ATL_FULL_OUT;
      end else if (o_y < 34'sd0) begin
         c_y = '0;
      end else begin
         c_y = o_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cd_v_r && cd_v_p && cd_v_y;
      end
      rsp_roll_angle  <= c_r[14:0];
      rsp_pitch_angle <= c_p[14:0];
      rsp_yaw_angle   <= c_y[14:0];
   end

endmodule

@@ design/atl_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atl_checker - port-level checks for the tilt-angle core
// Fixed latency, no stall, zero angles for an all-zero sample and no strobe straight after reset.
// ----------------------------------------------------------------------------
module atl_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic signed [7:0]  req_x_sample,
   input logic signed [7:0]  req_y_sample,
   input logic signed [7:0]  req_z_sample,
   input logic               rsp_valid,
   input logic signed [14:0] rsp_roll_angle,
   input logic signed [14:0] rsp_pitch_angle,
   input logic [14:0]        rsp_yaw_angle
);

   localparam int L = atl_pkg::ATL_LATENCY;

   // cycles since reset, saturating at the latency
   logic [6:0] age_ff;
   logic       armed;

   always_ff @(posedge clock) begin
      if (reset) begin
         age_ff <= '0;
      end else if (age_ff != 7'(L)) begin
         age_ff <= age_ff + 7'd1;
      end
   end

   assign armed = (age_ff == 7'(L));

   logic take, zero_in;
   assign take    = start && !busy;
   assign zero_in = (req_x_sample == 8'sd0) && (req_y_sample == 8'sd0) &&
                    (req_z_sample == 8'sd0);

   a_never_busy : assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_word_out : assert property (@(posedge clock) disable iff (reset)
      armed |-> (rsp_valid == $past(take, L)))
      else $error("result strobe does not match an accepted word");

   a_zero_in : assert property (@(posedge clock) disable iff (reset)
      (armed && rsp_valid && $past(zero_in, L)) |->
         (rsp_roll_angle == 15'sd0 && rsp_pitch_angle == 15'sd0 &&
          rsp_yaw_angle == 15'd0))
      else $error("all-zero sample gave non-zero angles");

   a_quiet_after_reset : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe straight after reset");

endmodule

bind accel_tilt_angles_core atl_checker u_atl_checker (.*);
